### design/line_pixel_rasterizer_defines.svh
// Assertion helpers shared by the rasteriser modules.
`ifndef LINE_PIXEL_RASTERIZER_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define LPR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define LPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpr: implication failed");

// Next-cycle implication.
`define LPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpr: next-cycle implication failed");

`else

`define LPR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define LPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/lpr_pkg.sv
`default_nettype none

package lpr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int PIX_W          = 16;
  localparam int COLOUR_W       = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEN_COLOUR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THICK_PEN  = 3'd5;

  // Position of the final pixel of a 2x2 quad
  localparam logic [1:0] QUAD_LAST = 2'd3;

  typedef enum logic [1:0] {
    DIR_STILL = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_t;

  typedef struct packed {
    logic [PIX_W-1:0]    start_x;
    logic [PIX_W-1:0]    start_y;
    logic [PIX_W-1:0]    end_x;
    logic [PIX_W-1:0]    end_y;
    logic [COLOUR_W-1:0] pen_colour;
    logic                thick_pen;
  } lpr_cfg_t;

  // One step handed from the stepping core to the pixel emitter
  typedef struct packed {
    logic [PIX_W-1:0]    x0;
    logic [PIX_W-1:0]    x1;
    logic [PIX_W-1:0]    y0;
    logic [PIX_W-1:0]    y1;
    logic [COLOUR_W-1:0] colour;
    logic                thick;
    logic                done;
  } lpr_step_t;

  typedef struct packed {
    logic restart;
  } lpr_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                last_of_step;
    logic                line_done;
  } lpr_pix_t;

endpackage

`default_nettype wire

### design/lpr_stream_if.sv
`default_nettype none

interface lpr_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/lpr_step_core.sv
`default_nettype none

`include "line_pixel_rasterizer_defines.svh"

module lpr_step_core #(
  parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_restart,
  input  logic              step_ready,
  input  lpr_pkg::lpr_cfg_t cfg,
  output logic              step_valid,
  output lpr_pkg::lpr_step_t step
);
  import lpr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 1;

  logic [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [EW-1:0] err_x_r, err_x_nxt, err_y_r, err_y_nxt;
  logic [CW-1:0] abs_dx_r, abs_dx_nxt, abs_dy_r, abs_dy_nxt;
  logic [CW-1:0] span_r, span_nxt;
  dir_t          dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic [EW-1:0] steps_left_r, steps_left_nxt;
  logic          running_r, running_nxt;
  logic [COLOUR_W-1:0] colour_r, colour_nxt;
  logic          thick_r, thick_nxt;

  logic [CW-1:0] sx, sy, ex, ey, ld_adx, ld_ady, ld_span;
  dir_t          ld_dirx, ld_diry;
  logic [EW-1:0] sum_x, sum_y;
  logic [CW-1:0] emit_x, emit_y, emit_x1, emit_y1;
  logic          accept, emit, emit_done, run_done;

  // Line set-up from the registers
  always_comb begin
    sx = cfg.start_x[CW-1:0];
    sy = cfg.start_y[CW-1:0];
    ex = cfg.end_x[CW-1:0];
    ey = cfg.end_y[CW-1:0];
    if (ex > sx) begin
      ld_adx  = ex - sx;
      ld_dirx = DIR_PLUS;
    end else if (ex == sx) begin
      ld_adx  = '0;
      ld_dirx = DIR_STILL;
    end else begin
      ld_adx  = sx - ex;
      ld_dirx = DIR_MINUS;
    end
    if (ey > sy) begin
      ld_ady  = ey - sy;
      ld_diry = DIR_PLUS;
    end else if (ey == sy) begin
      ld_ady  = '0;
      ld_diry = DIR_STILL;
    end else begin
      ld_ady  = sy - ey;
      ld_diry = DIR_MINUS;
    end
    ld_span = (ld_adx > ld_ady) ? ld_adx : ld_ady;
  end

  always_comb begin
    accept   = in_valid && step_ready;
    emit     = accept && (in_restart || running_r);
    run_done = (steps_left_r <= EW'(1));
    sum_x    = err_x_r + {1'b0, abs_dx_r};
    sum_y    = err_y_r + {1'b0, abs_dy_r};

    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    err_x_nxt      = err_x_r;
    err_y_nxt      = err_y_r;
    abs_dx_nxt     = abs_dx_r;
    abs_dy_nxt     = abs_dy_r;
    span_nxt       = span_r;
    dir_x_nxt      = dir_x_r;
    dir_y_nxt      = dir_y_r;
    steps_left_nxt = steps_left_r;
    running_nxt    = running_r;
    colour_nxt     = colour_r;
    thick_nxt      = thick_r;
    emit_x         = cur_x_r;
    emit_y         = cur_y_r;
    emit_done      = run_done;

    if (accept && in_restart) begin
      // First step: the start point, and no axis can move yet
      emit_x         = sx;
      emit_y         = sy;
      emit_done      = (ld_span == '0);
      cur_x_nxt      = sx;
      cur_y_nxt      = sy;
      err_x_nxt      = {1'b0, ld_adx};
      err_y_nxt      = {1'b0, ld_ady};
      abs_dx_nxt     = ld_adx;
      abs_dy_nxt     = ld_ady;
      span_nxt       = ld_span;
      dir_x_nxt      = ld_dirx;
      dir_y_nxt      = ld_diry;
      steps_left_nxt = {1'b0, ld_span};
      running_nxt    = (ld_span != '0);
      colour_nxt     = cfg.pen_colour;
      thick_nxt      = cfg.thick_pen;
    end else if (emit) begin
      err_x_nxt = sum_x;
      err_y_nxt = sum_y;
      if (sum_x > {1'b0, span_r}) begin
        err_x_nxt = sum_x - {1'b0, span_r};
        case (dir_x_r)
          DIR_PLUS:  cur_x_nxt = cur_x_r + 1'b1;
          DIR_MINUS: cur_x_nxt = cur_x_r - 1'b1;
          default:   cur_x_nxt = cur_x_r;
        endcase
      end
      if (sum_y > {1'b0, span_r}) begin
        err_y_nxt = sum_y - {1'b0, span_r};
        case (dir_y_r)
          DIR_PLUS:  cur_y_nxt = cur_y_r + 1'b1;
          DIR_MINUS: cur_y_nxt = cur_y_r - 1'b1;
          default:   cur_y_nxt = cur_y_r;
        endcase
      end
      if (run_done) begin
        steps_left_nxt = '0;
        running_nxt    = 1'b0;
      end else begin
        steps_left_nxt = steps_left_r - 1'b1;
      end
    end

    emit_x1     = emit_x + 1'b1;
    emit_y1     = emit_y + 1'b1;
    step_valid  = emit;
    step.x0     = PIX_W'(emit_x);
    step.x1     = PIX_W'(emit_x1);
    step.y0     = PIX_W'(emit_y);
    step.y1     = PIX_W'(emit_y1);
    step.colour = colour_nxt;
    step.thick  = thick_nxt;
    step.done   = emit_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      err_x_r      <= '0;
      err_y_r      <= '0;
      abs_dx_r     <= '0;
      abs_dy_r     <= '0;
      span_r       <= '0;
      dir_x_r      <= DIR_STILL;
      dir_y_r      <= DIR_STILL;
      steps_left_r <= '0;
      running_r    <= 1'b0;
      colour_r     <= '0;
      thick_r      <= 1'b0;
    end else begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      err_x_r      <= err_x_nxt;
      err_y_r      <= err_y_nxt;
      abs_dx_r     <= abs_dx_nxt;
      abs_dy_r     <= abs_dy_nxt;
      span_r       <= span_nxt;
      dir_x_r      <= dir_x_nxt;
      dir_y_r      <= dir_y_nxt;
      steps_left_r <= steps_left_nxt;
      running_r    <= running_nxt;
      colour_r     <= colour_nxt;
      thick_r      <= thick_nxt;
    end
  end

  `LPR_ASSERT_ALWAYS(a_run_count, clk, rst_n, running_r == (steps_left_r != '0), "lpr: step count out of step with running flag")
  `LPR_ASSERT_ALWAYS(a_err_bound, clk, rst_n, (err_x_r <= {1'b0, span_r}) && (err_y_r <= {1'b0, span_r}), "lpr: error term above span")
  `LPR_ASSERT_IMPL(a_delta_bound, clk, rst_n, running_r, (abs_dx_r <= span_r) && (abs_dy_r <= span_r))

endmodule

`default_nettype wire

### design/lpr_quad_emitter.sv
`default_nettype none

`include "line_pixel_rasterizer_defines.svh"

module lpr_quad_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_valid,
  input  lpr_pkg::lpr_step_t step,
  output logic               step_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lpr_pkg::lpr_pix_t  out_data
);
  import lpr_pkg::*;

  lpr_step_t  buf_r, buf_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] quad_r, quad_nxt;
  logic       take, last;

  always_comb begin
    last       = !buf_r.thick || (quad_r == QUAD_LAST);
    take       = valid_r && out_ready;
    step_ready = !valid_r || (take && last);

    buf_nxt   = buf_r;
    valid_nxt = valid_r;
    quad_nxt  = quad_r;
    if (step_valid) begin
      buf_nxt   = step;
      valid_nxt = 1'b1;
      quad_nxt  = '0;
    end else if (take) begin
      // advance through the quad, drop the step after its last pixel
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        quad_nxt = quad_r + 1'b1;
      end
    end

    out_valid             = valid_r;
    out_data.pixel_x      = quad_r[0] ? buf_r.x1 : buf_r.x0;
    out_data.pixel_y      = quad_r[1] ? buf_r.y1 : buf_r.y0;
    out_data.pixel_colour = buf_r.colour;
    out_data.last_of_step = last;
    out_data.line_done    = last && buf_r.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      quad_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      quad_r  <= quad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  `LPR_ASSERT_IMPL(a_thin_no_quad, clk, rst_n, valid_r && !buf_r.thick, quad_r == '0)
  `LPR_ASSERT_IMPL(a_load_free, clk, rst_n, step_valid, step_ready)
  `LPR_ASSERT_NEXT(a_drain_empty, clk, rst_n, take && last && !step_valid, !valid_r)

endmodule

`default_nettype wire

### design/line_pixel_rasterizer.sv
// Latency: a tick taken at one edge shows its first pixel on out_item after that edge.
// Throughput, while out_item is ready: thin pen one tick per cycle; thick pen holds each
// tick until the result channel has moved the four pixels of its 2x2 quad, one per cycle.
// Idle ticks (no line running, restart low) give no item and are taken whenever the
// output buffer is empty or hands out the last pixel of its step in that cycle.
// Reset: synchronous, active low; clears the registers, the line state and the output
// buffer. No clearing pass, the block takes items in the first cycle after reset.
`default_nettype none

module line_pixel_rasterizer #(
  parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lpr_stream_if.sink                        in_item,
  lpr_stream_if.source                      out_item,
  input  logic                              cfg_we,
  input  logic [lpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lpr_pkg::*;

  // Software-visible registers; the line engine latches them on restart
  lpr_cfg_t  cfg_r, cfg_nxt;

  lpr_step_t step;
  logic      step_valid;
  logic      step_ready;
  lpr_in_t   in_data;
  lpr_pix_t  out_data;

  // Hold every register unless written; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_START_X:    cfg_nxt.start_x    = cfg_data[PIX_W-1:0];
        REG_START_Y:    cfg_nxt.start_y    = cfg_data[PIX_W-1:0];
        REG_END_X:      cfg_nxt.end_x      = cfg_data[PIX_W-1:0];
        REG_END_Y:      cfg_nxt.end_y      = cfg_data[PIX_W-1:0];
        REG_PEN_COLOUR: cfg_nxt.pen_colour = cfg_data[COLOUR_W-1:0];
        REG_THICK_PEN:  cfg_nxt.thick_pen  = cfg_data[0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input side: an item is taken whenever the emitter can hold a new step, that is
  // when it is empty or its last pixel leaves in the same cycle. A thin pen keeps the
  // core at full rate while out_item is ready; a thick pen holds it through each quad.
  assign in_data       = in_item.data;
  assign in_item.ready = step_ready;

  // Stepping core: line set-up and one error-accumulator step per item while a line runs
  lpr_step_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_item.valid),
    .in_restart (in_data.restart),
    .step_ready (step_ready),
    .cfg        (cfg_r),
    .step_valid (step_valid),
    .step       (step)
  );

  // Output buffer: one pixel per step for a thin pen, four for a thick pen
  lpr_quad_emitter u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_valid),
    .step       (step),
    .step_ready (step_ready),
    .out_valid  (out_item.valid),
    .out_ready  (out_item.ready),
    .out_data   (out_data)
  );

  assign out_item.data = out_data;

endmodule

`default_nettype wire

### bench/line_pixel_rasterizer_test.sv
`timescale 1ns / 1ps

module line_pixel_rasterizer_test;
  import lpr_pkg::*;

  // Register indexes the block does not decode; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned SETTLE_CYCLES     = 4;
  localparam int unsigned TAIL_CYCLES       = 10;
  localparam int unsigned WATCHDOG_LIMIT    = 2000;
  localparam int unsigned RANDOM_LINE_TICKS = 350;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lpr_stream_if #(.data_t(lpr_in_t))  tick_if ();
  lpr_stream_if #(.data_t(lpr_pix_t)) pixel_if ();

  line_pixel_rasterizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (tick_if),
    .out_item  (pixel_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line predictor: register copies, the latched line and the stepping state
  // ---------------------------------------------------------------------------
  logic [15:0] reg_start_x = '0, reg_start_y = '0, reg_end_x = '0, reg_end_y = '0;
  logic [15:0] reg_colour  = '0;
  logic        reg_thick   = 1'b0;

  logic [15:0] cur_x = '0, cur_y = '0, abs_dx = '0, abs_dy = '0, major_span = '0;
  logic [17:0] err_x = '0, err_y = '0;
  logic [16:0] steps_left  = '0;
  dir_t        dir_x = DIR_STILL, dir_y = DIR_STILL;
  logic [15:0] line_colour = '0;
  logic        line_thick  = 1'b0;
  logic        running     = 1'b0;

  lpr_pix_t    pixel_queue[$];     // pixels still owed by the block, oldest first
  int unsigned sent_ticks    = 0;  // accepted items, idle ones included
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  bit          burst_mode    = 1'b0;

  // Typed-in expectation travelling with the item on the input channel
  logic        tick_typed;
  lpr_pix_t    tick_typed_pix;

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_START_X:    reg_start_x = value;
      REG_START_Y:    reg_start_y = value;
      REG_END_X:      reg_end_x   = value;
      REG_END_Y:      reg_end_y   = value;
      REG_PEN_COLOUR: reg_colour  = value;
      REG_THICK_PEN:  reg_thick   = value[0];
      default: ;
    endcase
  endfunction

  function automatic void axis_delta(input logic [15:0] from, input logic [15:0] to,
                                     output logic [15:0] span, output dir_t dir);
    if (to > from) begin
      span = to - from;
      dir  = DIR_PLUS;
    end else if (to == from) begin
      span = '0;
      dir  = DIR_STILL;
    end else begin
      span = from - to;
      dir  = DIR_MINUS;
    end
  endfunction

  function automatic logic [15:0] axis_step(input logic [15:0] pos, input dir_t dir);
    case (dir)
      DIR_PLUS:  return pos + 16'd1;
      DIR_MINUS: return pos - 16'd1;
      default:   return pos;
    endcase
  endfunction

  function automatic void queue_pixel(input logic [15:0] x, input logic [15:0] y,
                                      input logic last, input logic done);
    pixel_queue.push_back('{pixel_x: x, pixel_y: y, pixel_colour: line_colour,
                            last_of_step: last, line_done: done});
  endfunction

  // Advance the line by one item; return the number of pixels it owes
  function automatic int unsigned rasterise_tick(input logic restart);
    logic        done;
    logic [15:0] nx, ny;
    if (restart) begin
      axis_delta(reg_start_x, reg_end_x, abs_dx, dir_x);
      axis_delta(reg_start_y, reg_end_y, abs_dy, dir_y);
      major_span  = (abs_dx > abs_dy) ? abs_dx : abs_dy;
      cur_x       = reg_start_x;
      cur_y       = reg_start_y;
      err_x       = '0;
      err_y       = '0;
      steps_left  = {1'b0, major_span} + 17'd1;
      line_colour = reg_colour;
      line_thick  = reg_thick;
      running     = 1'b1;
    end
    if (!running) return 0;

    done = (steps_left <= 17'd1);
    nx   = cur_x + 16'd1;
    ny   = cur_y + 16'd1;
    if (line_thick) begin
      // quad order: origin, right, below, below-right (wraps at the edges)
      queue_pixel(cur_x, cur_y, 1'b0, 1'b0);
      queue_pixel(nx,    cur_y, 1'b0, 1'b0);
      queue_pixel(cur_x, ny,    1'b0, 1'b0);
      queue_pixel(nx,    ny,    1'b1, done);
    end else begin
      queue_pixel(cur_x, cur_y, 1'b1, done);
    end

    // an axis moves only once its error strictly exceeds the major span
    err_x = err_x + abs_dx;
    err_y = err_y + abs_dy;
    if (err_x > {2'b00, major_span}) begin
      err_x = err_x - major_span;
      cur_x = axis_step(cur_x, dir_x);
    end
    if (err_y > {2'b00, major_span}) begin
      err_y = err_y - major_span;
      cur_y = axis_step(cur_y, dir_y);
    end

    if (done) begin
      steps_left = '0;
      running    = 1'b0;
    end else begin
      steps_left = steps_left - 17'd1;
    end
    return line_thick ? 4 : 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard and watchdog: both channels sampled at the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    lpr_pix_t    want;
    int unsigned base, drawn;
    if (rst_n) begin
      if (tick_if.valid && tick_if.ready) begin
        base  = pixel_queue.size();
        drawn = rasterise_tick(tick_if.data.restart);
        sent_ticks++;
        // a typed-in row overrides the predicted pixel of a thin step
        if (tick_typed && drawn == 1) pixel_queue[base] = tick_typed_pix;
      end

      if (pixel_if.valid && pixel_if.ready) begin
        if (pixel_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel x=%h y=%h colour=%h last=%b done=%b", $time,
                   pixel_if.data.pixel_x, pixel_if.data.pixel_y,
                   pixel_if.data.pixel_colour, pixel_if.data.last_of_step,
                   pixel_if.data.line_done);
        end else begin
          want = pixel_queue.pop_front();
          if (pixel_if.data.pixel_x !== want.pixel_x ||
              pixel_if.data.pixel_y !== want.pixel_y ||
              pixel_if.data.pixel_colour !== want.pixel_colour ||
              pixel_if.data.last_of_step !== want.last_of_step ||
              pixel_if.data.line_done !== want.line_done) begin
            mismatches++;
            $display("%0t: pixel mismatch, expected x=%h y=%h colour=%h last=%b done=%b",
                     $time, want.pixel_x, want.pixel_y, want.pixel_colour,
                     want.last_of_step, want.line_done);
            $display("%0t:                 actual   x=%h y=%h colour=%h last=%b done=%b",
                     $time, pixel_if.data.pixel_x, pixel_if.data.pixel_y,
                     pixel_if.data.pixel_colour, pixel_if.data.last_of_step,
                     pixel_if.data.line_done);
          end
        end
      end

      // any handshake or register write counts as progress
      if ((tick_if.valid && tick_if.ready) || (pixel_if.valid && pixel_if.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel sink: stall a random number of cycles before each item
  // ---------------------------------------------------------------------------
  initial begin : pixel_sink
    int unsigned stall;
    pixel_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        pixel_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pixel_if.ready <= 1'b1;
      do @(posedge clk); while (!pixel_if.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap; return once it has been taken
  task automatic send_tick(input logic restart, input logic typed, input lpr_pix_t pix);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid        <= 1'b1;
    tick_if.data.restart <= restart;
    tick_typed           <= typed;
    tick_typed_pix       <= pix;
    do @(posedge clk); while (!tick_if.ready);
  endtask

  // Hold the sender, drain every owed pixel and let the pipeline settle
  task automatic quiesce();
    tick_if.valid <= 1'b0;
    @(posedge clk);
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller lowers cfg_we after the last write of a burst
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_reg(idx, value);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 3));
      3:       return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly short spans; now and then a longer one
  function automatic logic [15:0] near_coord(input logic [15:0] from);
    int reach, delta;
    reach = ($urandom_range(0, 4) == 0) ? 60 : 8;
    delta = int'($urandom_range(0, 2 * reach)) - reach;
    return from + delta[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan: register writes and items, some with the pixel typed in
  // ---------------------------------------------------------------------------
  typedef enum logic { ROW_WRITE, ROW_TICK } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  restart;
    logic                  typed;
    lpr_pix_t              pix;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] value);
    plan.push_back('{kind: ROW_WRITE, idx: idx, value: value, restart: 1'b0,
                     typed: 1'b0, pix: '0});
  endfunction

  function automatic void plan_tick(input logic restart);
    plan.push_back('{kind: ROW_TICK, idx: '0, value: '0, restart: restart,
                     typed: 1'b0, pix: '0});
  endfunction

  // Thin step whose single pixel is known up front
  function automatic void plan_check(input logic restart, input logic [15:0] x,
                                     input logic [15:0] y, input logic [15:0] colour,
                                     input logic done);
    plan.push_back('{kind: ROW_TICK, idx: '0, value: '0, restart: restart, typed: 1'b1,
                     pix: '{pixel_x: x, pixel_y: y, pixel_colour: colour,
                            last_of_step: 1'b1, line_done: done}});
  endfunction

  initial begin : stimulus
    logic [15:0] sx, sy, ex, ey, colour, thick_word, span_x, span_y, span;
    dir_t        dir_tmp;
    int unsigned goal, n, pause_at;
    bit          fresh;

    tick_if.valid  <= 1'b0;
    tick_if.data   <= '0;
    tick_typed     <= 1'b0;
    tick_typed_pix <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // idle item straight after reset, then the all-zero line: start equals end
    plan_tick(1'b0);
    plan_check(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    plan_tick(1'b0);
    // top corner, full colour, single step
    plan_write(REG_START_X, 16'hFFFF);
    plan_write(REG_START_Y, 16'hFFFF);
    plan_write(REG_END_X, 16'hFFFF);
    plan_write(REG_END_Y, 16'hFFFF);
    plan_write(REG_PEN_COLOUR, 16'hFFFF);
    plan_check(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // thick quad at the corner wraps on both axes
    plan_write(REG_THICK_PEN, 16'h0001);
    plan_tick(1'b1);
    plan_tick(1'b0);
    // spare indexes are ignored; short horizontal thin line
    plan_write(REG_SPARE_LO, 16'hFFFF);
    plan_write(REG_SPARE_HI, 16'h0000);
    plan_write(REG_THICK_PEN, 16'h0000);
    plan_write(REG_START_X, 16'h0000);
    plan_write(REG_START_Y, 16'h0000);
    plan_write(REG_END_X, 16'h0003);
    plan_write(REG_END_Y, 16'h0000);
    plan_write(REG_PEN_COLOUR, 16'h5AA5);
    plan_check(1'b1, 16'h0000, 16'h0000, 16'h5AA5, 1'b0);
    repeat (4) plan_tick(1'b0);
    // thick line heading down-left, registers rewritten part way along
    plan_write(REG_START_X, 16'd10);
    plan_write(REG_START_Y, 16'd10);
    plan_write(REG_END_X, 16'd7);
    plan_write(REG_END_Y, 16'd12);
    plan_write(REG_THICK_PEN, 16'h0001);
    plan_tick(1'b1);
    plan_tick(1'b0);
    plan_tick(1'b0);
    plan_write(REG_END_X, 16'hFFFF);
    plan_write(REG_PEN_COLOUR, 16'h0000);
    plan_write(REG_THICK_PEN, 16'h0000);
    plan_tick(1'b0);
    plan_tick(1'b0);
    // full diagonal, abandoned by a restart, then the other full diagonal
    plan_write(REG_START_X, 16'h0000);
    plan_write(REG_START_Y, 16'h0000);
    plan_write(REG_END_X, 16'hFFFF);
    plan_write(REG_END_Y, 16'hFFFF);
    plan_check(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    repeat (3) plan_tick(1'b0);
    plan_write(REG_START_X, 16'hFFFF);
    plan_write(REG_START_Y, 16'h0000);
    plan_write(REG_END_X, 16'h0000);
    plan_write(REG_END_Y, 16'hFFFF);
    plan_tick(1'b1);
    plan_tick(1'b0);
    plan_tick(1'b0);
    // collapse to a point: restart ends the long line at once
    plan_write(REG_END_X, 16'hFFFF);
    plan_write(REG_END_Y, 16'h0000);
    plan_check(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);

    // walk the plan; a burst of writes waits for the block to go quiet first
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind != ROW_WRITE) quiesce();
        write_reg(plan[i].idx, plan[i].value);
        if (i + 1 == plan.size() || plan[i+1].kind != ROW_WRITE) cfg_we <= 1'b0;
      end else begin
        send_tick(plan[i].restart, plan[i].typed, plan[i].pix);
      end
    end

    // random lines: fresh settings per phase, short ones stepped to the end and a little past
    goal = sent_ticks + RANDOM_LINE_TICKS;
    while (sent_ticks < goal) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      quiesce();
      sx         = pick_coord();
      sy         = pick_coord();
      ex         = ($urandom_range(0, 7) == 0) ? pick_coord() : near_coord(sx);
      ey         = ($urandom_range(0, 7) == 0) ? pick_coord() : near_coord(sy);
      colour     = ($urandom_range(0, 4) == 0) ? 16'hFFFF :
                   ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
      thick_word = 16'($urandom_range(0, 65535));
      write_reg(REG_START_X, sx);
      write_reg(REG_START_Y, sy);
      write_reg(REG_END_X, ex);
      write_reg(REG_END_Y, ey);
      write_reg(REG_PEN_COLOUR, colour);
      write_reg(REG_THICK_PEN, thick_word);
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                  16'($urandom_range(0, 65535)));
      cfg_we <= 1'b0;

      // now and then carry on the previous line under the new settings
      fresh = ($urandom_range(0, 4) != 0);
      axis_delta(sx, ex, span_x, dir_tmp);
      axis_delta(sy, ey, span_y, dir_tmp);
      span = (span_x > span_y) ? span_x : span_y;
      if (!fresh)
        n = $urandom_range(1, 12);
      else if (span < 70)
        n = span + 1 + $urandom_range(0, 2);
      else
        n = $urandom_range(4, 30);
      pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : n;

      for (int k = 0; k < n; k++) begin
        if (k == pause_at) quiesce();
        send_tick((k == 0 && fresh) || $urandom_range(0, 39) == 0, 1'b0, '0);
      end
    end

    // drain, give the block time to show any stray pixel, then report
    burst_mode = 1'b0;
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
